FILE: hdl/mtep_pkg.sv
// mtep_pkg: shared types, codes and helpers for the midi track event parser
// no dependencies; imported by every module under hdl
package mtep_pkg;

  // byte and event constants
  localparam logic [7:0] DATA_MASK    = 8'h7F;
  localparam logic [7:0] STAT_NOTEOFF = 8'h80;
  localparam logic [7:0] STAT_NOTEON  = 8'h90;
  localparam logic [7:0] STAT_POLYAT  = 8'hA0;
  localparam logic [7:0] STAT_CTRL    = 8'hB0;
  localparam logic [7:0] STAT_PROG    = 8'hC0;
  localparam logic [7:0] STAT_CHANAT  = 8'hD0;
  localparam logic [7:0] STAT_BEND    = 8'hE0;
  localparam logic [7:0] STAT_SYSEX   = 8'hF0;
  localparam logic [7:0] STAT_META    = 8'hFF;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] HI_NIBBLE    = 8'hF0;

  localparam logic [31:0] TEMPO_LEN   = 32'd3;
  localparam logic [1:0]  TEMPO_LAST  = 2'd3;

  // event kinds
  localparam logic [1:0] KIND_TWO_DATA = 2'd0;
  localparam logic [1:0] KIND_ONE_DATA = 2'd1;
  localparam logic [1:0] KIND_TEMPO    = 2'd2;

  typedef enum logic [8:0] {
    PH_DELTA     = 9'b0_0000_0001,
    PH_STATUS    = 9'b0_0000_0010,
    PH_DATA1     = 9'b0_0000_0100,
    PH_DATA2     = 9'b0_0000_1000,
    PH_META_TYPE = 9'b0_0001_0000,
    PH_META_LEN  = 9'b0_0010_0000,
    PH_TEMPO     = 9'b0_0100_0000,
    PH_SYSEX_LEN = 9'b0_1000_0000,
    PH_SKIP      = 9'b1_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [31:0] tick;
    logic [23:0] tempo_us_per_quarter;
    logic        note_on;
    logic        note_off;
  } result_t;

  function automatic logic is_two_data(input logic [7:0] st);
    logic [7:0] t;
    t = st & HI_NIBBLE;
    return (t == STAT_NOTEOFF) || (t == STAT_NOTEON) || (t == STAT_POLYAT) ||
           (t == STAT_CTRL) || (t == STAT_BEND);
  endfunction

  function automatic logic is_one_data(input logic [7:0] st);
    logic [7:0] t;
    t = st & HI_NIBBLE;
    return (t == STAT_PROG) || (t == STAT_CHANAT);
  endfunction

endpackage

FILE: hdl/mtep_input_stage.sv
// mtep_input_stage: input register holding one track byte for the parser
// depends on mtep_pkg (item_t)
module mtep_input_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mtep_pkg::item_t in_item,
  output logic           held_valid,
  output mtep_pkg::item_t held_item,
  input  logic           advance
);
  import mtep_pkg::*;

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

FILE: hdl/mtep_parser.sv
// mtep_parser: parse state registers and the one-byte next-state logic
// depends on mtep_pkg (phase_t, item_t, result_t, status helpers)
module mtep_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  mtep_pkg::item_t  item,
  output logic             emit,
  output mtep_pkg::result_t result
);
  import mtep_pkg::*;

  phase_t      phase, phase_e, phase_next;
  logic [7:0]  running_status, running_status_e, running_status_next;
  logic [31:0] tick_count, tick_count_e, tick_count_next;
  logic [31:0] varlen_accum, varlen_accum_e, varlen_accum_next;
  logic [31:0] skip_remaining, skip_remaining_e, skip_remaining_next;
  logic [7:0]  current_status, current_status_e, current_status_next;
  logic [7:0]  first_data, first_data_e, first_data_next;
  logic [7:0]  meta_kind, meta_kind_e, meta_kind_next;
  logic [23:0] tempo_accum, tempo_accum_e, tempo_accum_next;
  logic [1:0]  tempo_byte_index, tempo_byte_index_e, tempo_byte_index_next;

  logic [7:0]  b;
  logic        taken;
  logic        do_body;
  logic [7:0]  st;
  logic [31:0] vl_shift;
  logic [7:0]  hi;

  assign b = item.data_byte;

  // track start clears everything before the byte is parsed
  always_comb begin
    if (item.track_start) begin
      phase_e            = PH_DELTA;
      running_status_e   = '0;
      tick_count_e       = '0;
      varlen_accum_e     = '0;
      skip_remaining_e   = '0;
      current_status_e   = '0;
      first_data_e       = '0;
      meta_kind_e        = '0;
      tempo_accum_e      = '0;
      tempo_byte_index_e = '0;
    end else begin
      phase_e            = phase;
      running_status_e   = running_status;
      tick_count_e       = tick_count;
      varlen_accum_e     = varlen_accum;
      skip_remaining_e   = skip_remaining;
      current_status_e   = current_status;
      first_data_e       = first_data;
      meta_kind_e        = meta_kind;
      tempo_accum_e      = tempo_accum;
      tempo_byte_index_e = tempo_byte_index;
    end
  end

  always_comb begin
    phase_next            = phase_e;
    running_status_next   = running_status_e;
    tick_count_next       = tick_count_e;
    varlen_accum_next     = varlen_accum_e;
    skip_remaining_next   = skip_remaining_e;
    current_status_next   = current_status_e;
    first_data_next       = first_data_e;
    meta_kind_next        = meta_kind_e;
    tempo_accum_next      = tempo_accum_e;
    tempo_byte_index_next = tempo_byte_index_e;
    emit                  = 1'b0;
    result                = '0;
    result.tick           = tick_count_e;
    taken                 = b[7];
    do_body               = 1'b0;
    st                    = '0;
    vl_shift              = '0;
    hi                    = '0;

    // first pass: delta time and status position
    unique case (phase_e)
      PH_DELTA: begin
        vl_shift = {varlen_accum_e[24:0], b[6:0]};
        if (!b[7]) begin
          tick_count_next   = tick_count_e + vl_shift;
          varlen_accum_next = '0;
          phase_next        = PH_STATUS;
        end else begin
          varlen_accum_next = vl_shift;
        end
      end
      PH_STATUS: begin
        st = taken ? b : running_status_e;
        running_status_next = st;
        current_status_next = st;
        if (is_two_data(st) || is_one_data(st)) begin
          phase_next = PH_DATA1;
          do_body    = !taken;
        end else if (st == STAT_META) begin
          running_status_next = '0;
          phase_next          = PH_META_TYPE;
          do_body             = !taken;
        end else if (st == STAT_SYSEX) begin
          varlen_accum_next = '0;
          phase_next        = PH_SYSEX_LEN;
          do_body           = !taken;
        end else if (taken) begin
          // unknown status: drop it and the byte after it
          skip_remaining_next = 32'd1;
          phase_next          = PH_SKIP;
        end else begin
          phase_next = PH_DELTA;
        end
      end
      default: begin
        do_body = 1'b1;
      end
    endcase

    // second pass: body bytes, from the phase left by the first pass
    if (do_body) begin
      unique case (phase_next)
        PH_DATA1: begin
          if (is_two_data(current_status_next)) begin
            first_data_next = b;
            phase_next      = PH_DATA2;
          end else begin
            phase_next        = PH_DELTA;
            emit              = 1'b1;
            result.event_kind = KIND_ONE_DATA;
            result.status     = current_status_next;
            result.data1      = b;
          end
        end
        PH_DATA2: begin
          hi                = current_status_next & HI_NIBBLE;
          phase_next        = PH_DELTA;
          emit              = 1'b1;
          result.event_kind = KIND_TWO_DATA;
          result.status     = current_status_next;
          result.data1      = first_data_next;
          result.data2      = b;
          result.note_on    = (hi == STAT_NOTEON) && (b != 8'd0);
          result.note_off   = (hi == STAT_NOTEOFF) || ((hi == STAT_NOTEON) && (b == 8'd0));
        end
        PH_META_TYPE: begin
          meta_kind_next    = b;
          varlen_accum_next = '0;
          phase_next        = PH_META_LEN;
        end
        PH_META_LEN, PH_SYSEX_LEN: begin
          vl_shift = {varlen_accum_next[24:0], b[6:0]};
          if (b[7]) begin
            varlen_accum_next = vl_shift;
          end else begin
            varlen_accum_next = '0;
            if ((phase_next == PH_META_LEN) && (meta_kind_next == META_TEMPO) &&
                (vl_shift == TEMPO_LEN)) begin
              tempo_accum_next      = '0;
              tempo_byte_index_next = '0;
              phase_next            = PH_TEMPO;
            end else if (vl_shift == 32'd0) begin
              phase_next = PH_DELTA;
            end else begin
              skip_remaining_next = vl_shift;
              phase_next          = PH_SKIP;
            end
          end
        end
        PH_TEMPO: begin
          tempo_accum_next      = {tempo_accum_next[15:0], b};
          tempo_byte_index_next = tempo_byte_index_next + 2'd1;
          if (tempo_byte_index_next == TEMPO_LAST) begin
            tempo_byte_index_next       = '0;
            phase_next                  = PH_DELTA;
            emit                        = 1'b1;
            result.event_kind           = KIND_TEMPO;
            result.status               = STAT_META;
            result.tempo_us_per_quarter = tempo_accum_next;
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip_remaining_next - 32'd1;
          if (skip_remaining_next == 32'd0) begin
            phase_next = PH_DELTA;
          end
        end
        default: begin
          phase_next = PH_DELTA;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_DELTA;
      running_status   <= '0;
      tick_count       <= '0;
      varlen_accum     <= '0;
      skip_remaining   <= '0;
      current_status   <= '0;
      first_data       <= '0;
      meta_kind        <= '0;
      tempo_accum      <= '0;
      tempo_byte_index <= '0;
    end else if (step) begin
      phase            <= phase_next;
      running_status   <= running_status_next;
      tick_count       <= tick_count_next;
      varlen_accum     <= varlen_accum_next;
      skip_remaining   <= skip_remaining_next;
      current_status   <= current_status_next;
      first_data       <= first_data_next;
      meta_kind        <= meta_kind_next;
      tempo_accum      <= tempo_accum_next;
      tempo_byte_index <= tempo_byte_index_next;
    end
  end

  // an event always ends the message
  a_emit_to_delta: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> phase == PH_DELTA)
    else $error("phase not back at delta time after an event");

  // meta status never survives as running status
  a_running_status: assert property (@(posedge clk) disable iff (rst)
    running_status == 8'd0 || (running_status[7] && running_status != STAT_META))
    else $error("running status holds a data byte or meta status");

  // the tempo byte counter wraps at three
  a_tempo_index: assert property (@(posedge clk) disable iff (rst)
    tempo_byte_index != TEMPO_LAST)
    else $error("tempo byte index reached three");

  // bytes are only skipped with a count left
  a_skip_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_remaining != 32'd0)
    else $error("skip phase with nothing left to skip");

endmodule

FILE: hdl/mtep_output_stage.sv
// mtep_output_stage: result register between the parser and the output port
// depends on mtep_pkg (result_t)
module mtep_output_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mtep_pkg::result_t load_result,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output mtep_pkg::result_t out_result
);
  import mtep_pkg::*;

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= load_result;
    end
  end

endmodule

FILE: hdl/midi_track_event_parser.sv
// midi_track_event_parser: top level, track body bytes in, channel and tempo events out
// depends on mtep_pkg, mtep_input_stage, mtep_parser, mtep_output_stage
//
//   channel | handshake             | beat payload
//   --------+-----------------------+---------------------------------------------
//   in      | in_valid / in_ready   | data_byte, track_start
//   out     | out_valid / out_ready | event_kind, status, data1, data2, tick,
//           |                       | tempo_us_per_quarter, note_on, note_off
//
// one byte per cycle unless an event byte waits for the result register; a byte is
// parsed from the input register; its event, if any, is loaded into the result register
// the per-byte state update (tick adder, length shift, skip count) is combinational
// rst is synchronous: parser at delta time, tick and running status zero, no beat held
// a byte that makes no event moves on while out is stalled; a byte that makes an event
// waits in the input register until the result register frees up
module midi_track_event_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        track_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [7:0]  status,
  output logic [7:0]  data1,
  output logic [7:0]  data2,
  output logic [31:0] tick,
  output logic [23:0] tempo_us_per_quarter,
  output logic        note_on,
  output logic        note_off
);
  import mtep_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    emit;
  logic    space;
  result_t parsed;
  result_t out_result;

  assign in_item.data_byte   = data_byte;
  assign in_item.track_start = track_start;

  // the held byte steps the parser unless it has an event with nowhere to go
  assign advance = held_valid && (!emit || space);

  mtep_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .advance    (advance)
  );

  mtep_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (held_item),
    .emit   (emit),
    .result (parsed)
  );

  mtep_output_stage u_output (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && emit),
    .load_result (parsed),
    .space       (space),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result)
  );

  assign event_kind           = out_result.event_kind;
  assign status               = out_result.status;
  assign data1                = out_result.data1;
  assign data2                = out_result.data2;
  assign tick                 = out_result.tick;
  assign tempo_us_per_quarter = out_result.tempo_us_per_quarter;
  assign note_on              = out_result.note_on;
  assign note_off             = out_result.note_off;

endmodule
